>>> rtl/core/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants for the response deframer: parser phases,
// frame signature bytes, result kinds and status codes.
// ----------------------------------------------------------------------------
package msp_pkg;

    typedef enum logic [2:0] {
        PH_SIG0    = 3'd0,
        PH_SIG1    = 3'd1,
        PH_SIG2    = 3'd2,
        PH_SIZE    = 3'd3,
        PH_CMD     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CHECK   = 3'd6
    } t_phase;

    localparam logic [7:0] SIG0_BYTE = 8'h24;
    localparam logic [7:0] SIG1_BYTE = 8'h4D;
    localparam logic [7:0] SIG2_BYTE = 8'h3E;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIG  = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE = 2'd2;
    localparam logic [1:0] ST_BAD_SUM  = 2'd3;

endpackage

>>> rtl/core/msp_if.sv
// ----------------------------------------------------------------------------
// msp channel interfaces
// Valid/ready channels for received bytes, parser results and the
// expected size register write.
// ----------------------------------------------------------------------------
interface msp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface msp_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] command_id;
    logic [1:0] status;

    modport source (output valid, output kind, output data_byte, output byte_index,
                    output command_id, output status, input ready);
    modport sink   (input valid, input kind, input data_byte, input byte_index,
                    input command_id, input status, output ready);
endinterface

interface msp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] expected_size;

    modport source (output valid, output expected_size, input ready);
    modport sink   (input valid, input expected_size, output ready);
endinterface

>>> rtl/core/msp_response_deframer.sv
// ----------------------------------------------------------------------------
// msp_response_deframer
// A byte is held in the input register, then its result item in the result
// register; a held result item can stall the byte between the two.
// Throughput: one byte per cycle; a held result item stalls only a byte that
// produces a result, and rx ready follows result ready within the cycle.
// Reset (synchronous, active low) idles the parser at the first signature
// byte and clears expected size to zero.
// ----------------------------------------------------------------------------
module msp_response_deframer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    msp_rx_if.sink           i_rx,
    msp_res_if.source        o_res,
    msp_cfg_if.sink          i_cfg
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // parser state
    msp_pkg::t_phase r_phase, n_phase;
    logic       r_sig_ok, n_sig_ok;
    logic [7:0] r_frame_size, n_frame_size;
    logic [7:0] r_frame_cmd, n_frame_cmd;
    logic [7:0] r_pay_cnt, n_pay_cnt;
    logic [7:0] r_check, n_check;
    logic [7:0] r_exp_size;

    // result register
    logic       r_out_valid;
    logic       r_out_kind, n_out_kind;
    logic [7:0] r_out_data, n_out_data;
    logic [7:0] r_out_index, n_out_index;
    logic [7:0] r_out_cmd, n_out_cmd;
    logic [1:0] r_out_status, n_out_status;

    logic       has_result;
    logic       out_free;
    logic       proc_fire;
    logic [7:0] pay_cnt_inc;

    assign out_free    = !r_out_valid || o_res.ready;
    assign proc_fire   = r_in_valid && (!has_result || out_free);
    assign i_rx.ready  = !r_in_valid || proc_fire;
    assign i_cfg.ready = 1'b1;
    assign pay_cnt_inc = r_pay_cnt + 8'd1;

    assign o_res.valid      = r_out_valid;
    assign o_res.kind       = r_out_kind;
    assign o_res.data_byte  = r_out_data;
    assign o_res.byte_index = r_out_index;
    assign o_res.command_id = r_out_cmd;
    assign o_res.status     = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_size <= 8'd0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_exp_size <= i_cfg.expected_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= msp_pkg::PH_SIG0;
            r_sig_ok     <= 1'b1;
            r_frame_size <= 8'd0;
            r_frame_cmd  <= 8'd0;
            r_pay_cnt    <= 8'd0;
            r_check      <= 8'd0;
        end else if (proc_fire) begin
            r_phase      <= n_phase;
            r_sig_ok     <= n_sig_ok;
            r_frame_size <= n_frame_size;
            r_frame_cmd  <= n_frame_cmd;
            r_pay_cnt    <= n_pay_cnt;
            r_check      <= n_check;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_sig_ok     = r_sig_ok;
        n_frame_size = r_frame_size;
        n_frame_cmd  = r_frame_cmd;
        n_pay_cnt    = r_pay_cnt;
        n_check      = r_check;
        has_result   = 1'b0;
        n_out_kind   = msp_pkg::KIND_STATUS;
        n_out_data   = 8'd0;
        n_out_index  = 8'd0;
        n_out_cmd    = r_frame_cmd;
        n_out_status = msp_pkg::ST_OK;
        unique case (r_phase)
            msp_pkg::PH_SIG1: begin
                if (r_in_byte != msp_pkg::SIG1_BYTE) begin
                    n_sig_ok = 1'b0;
                end
                n_phase = msp_pkg::PH_SIG2;
            end
            msp_pkg::PH_SIG2: begin
                if (r_in_byte != msp_pkg::SIG2_BYTE) begin
                    n_sig_ok = 1'b0;
                end
                n_phase = msp_pkg::PH_SIZE;
            end
            msp_pkg::PH_SIZE: begin
                n_frame_size = r_in_byte;
                n_phase      = msp_pkg::PH_CMD;
            end
            msp_pkg::PH_CMD: begin
                n_frame_cmd = r_in_byte;
                n_check     = r_frame_size ^ r_in_byte;
                n_pay_cnt   = 8'd0;
                n_out_cmd   = r_in_byte;
                // signature fault wins over a size mismatch
                if (!r_sig_ok) begin
                    has_result   = 1'b1;
                    n_out_status = msp_pkg::ST_BAD_SIG;
                    n_phase      = msp_pkg::PH_SIG0;
                    n_sig_ok     = 1'b1;
                end else if (r_frame_size != r_exp_size) begin
                    has_result   = 1'b1;
                    n_out_status = msp_pkg::ST_BAD_SIZE;
                    n_phase      = msp_pkg::PH_SIG0;
                    n_sig_ok     = 1'b1;
                end else if (r_frame_size == 8'd0) begin
                    n_phase = msp_pkg::PH_CHECK;
                end else begin
                    n_phase = msp_pkg::PH_PAYLOAD;
                end
            end
            msp_pkg::PH_PAYLOAD: begin
                has_result  = 1'b1;
                n_out_kind  = msp_pkg::KIND_PAYLOAD;
                n_out_data  = r_in_byte;
                n_out_index = r_pay_cnt;
                n_check     = r_check ^ r_in_byte;
                n_pay_cnt   = pay_cnt_inc;
                if (pay_cnt_inc == r_frame_size) begin
                    n_phase = msp_pkg::PH_CHECK;
                end
            end
            msp_pkg::PH_CHECK: begin
                has_result   = 1'b1;
                n_out_status = (r_in_byte == r_check) ? msp_pkg::ST_OK
                                                      : msp_pkg::ST_BAD_SUM;
                n_phase      = msp_pkg::PH_SIG0;
                n_sig_ok     = 1'b1;
                n_pay_cnt    = 8'd0;
            end
            default: begin
                // first signature byte, also the unused phase code
                n_sig_ok  = (r_in_byte == msp_pkg::SIG0_BYTE);
                n_pay_cnt = 8'd0;
                n_phase   = msp_pkg::PH_SIG1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (proc_fire && has_result) begin
            r_out_kind   <= n_out_kind;
            r_out_data   <= n_out_data;
            r_out_index  <= n_out_index;
            r_out_cmd    <= n_out_cmd;
            r_out_status <= n_out_status;
        end
    end

`ifndef NO_ASSERTIONS
    a_payload_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == msp_pkg::KIND_PAYLOAD |-> r_out_status == msp_pkg::ST_OK)
        else $error("payload item carries a nonzero status");

    a_status_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == msp_pkg::KIND_STATUS
            |-> r_out_data == 8'd0 && r_out_index == 8'd0)
        else $error("status item carries payload data");

    a_payload_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == msp_pkg::PH_PAYLOAD |-> r_pay_cnt < r_frame_size)
        else $error("payload count ran past frame size");

    a_check_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && r_phase == msp_pkg::PH_CHECK |=> r_phase == msp_pkg::PH_SIG0)
        else $error("parser did not idle after checksum byte");

    a_result_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && has_result && r_out_valid |-> o_res.ready)
        else $error("result register overwritten while held");
`endif

endmodule
